>>> sv/stereo_level_dependent_slew_limiter_macros.svh
// Assertion macros for the stereo slew limiter.
// Needs a clock named clock and an active-high reset named reset in scope.
`ifndef STEREO_LEVEL_DEPENDENT_SLEW_LIMITER_MACROS_SVH
`define STEREO_LEVEL_DEPENDENT_SLEW_LIMITER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define SLDSL_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SLDSL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/sldsl_pkg.sv
// Shared types and fixed constants of the stereo slew limiter.
// No dependencies.
`timescale 1ns / 1ps

package sldsl_pkg;

   // threshold register: unsigned Q1.22
   localparam int THRESH_W    = 23;
   localparam int THRESH_FRAC = 22;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 23'd4194304;

   // cosine table entries: unsigned Q1.22
   localparam int COS_W    = 23;
   localparam int COS_FRAC = 22;

   // squared magnitude kept as Q28, range 0..1.0
   localparam int SQ_FRAC = 28;
   localparam int SQ_W    = SQ_FRAC + 1;

   // per-lane stage strobes from the sequencer
   typedef struct packed {
      logic load;
      logic index;
      logic lookup;
      logic scale;
      logic commit;
   } sldsl_ctrl_type;

endpackage

>>> sv/sldsl_if.sv
// Request and response channel interfaces of the stereo slew limiter.
// Valid/ready handshake; no package dependencies.
`timescale 1ns / 1ps

interface sldsl_req_if #(parameter int SAMPLE_WIDTH = 24) ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_left;
   logic signed [SAMPLE_WIDTH-1:0] sample_right;

   modport source (output valid, output sample_left, output sample_right, input ready);
   modport sink   (input valid, input sample_left, input sample_right, output ready);
endinterface

interface sldsl_rsp_if #(parameter int SAMPLE_WIDTH = 24) ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] out_left;
   logic signed [SAMPLE_WIDTH-1:0] out_right;

   modport source (output valid, output out_left, output out_right, input ready);
   modport sink   (input valid, input out_left, input out_right, output ready);
endinterface

>>> sv/sldsl_lane.sv
// One channel of the slew limiter: square, cosine lookup, step scale and limit.
// Depends on sldsl_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "stereo_level_dependent_slew_limiter_macros.svh"

module sldsl_lane #(
   parameter int COS_TABLE_ENTRIES = 256,
   parameter int SAMPLE_WIDTH      = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  sldsl_pkg::sldsl_ctrl_type             ctrl,
   input  logic [sldsl_pkg::THRESH_W-1:0]        thresh,
   input  logic signed [SAMPLE_WIDTH-1:0]        sample,
   output logic signed [SAMPLE_WIDTH-1:0]        y_sat
);
   import sldsl_pkg::*;

   localparam int FRAC_W     = SAMPLE_WIDTH - 2;
   localparam int MAG_W      = FRAC_W + 1;
   localparam int IDX_W      = $clog2(COS_TABLE_ENTRIES);
   localparam int COS_DEN    = COS_TABLE_ENTRIES - 1;
   localparam int SQ_SHIFT   = 2 * FRAC_W - SQ_FRAC;
   localparam int IPROD_W    = SQ_W + IDX_W + 1;
   localparam int STEP_SHIFT = THRESH_FRAC + COS_FRAC - FRAC_W;
   localparam int SPROD_W    = THRESH_W + COS_W + 1;
   localparam int CMP_W      = SAMPLE_WIDTH + 2;

   localparam logic [IPROD_W-1:0] IDX_HALF  = IPROD_W'(1) << (SQ_FRAC - 1);
   localparam logic [SPROD_W-1:0] STEP_HALF = SPROD_W'(1) << (STEP_SHIFT - 1);
   localparam logic signed [CMP_W-1:0] UNITY_C  = CMP_W'(1) << FRAC_W;
   localparam logic signed [CMP_W-1:0] NUNITY_C = -UNITY_C;
   localparam logic signed [CMP_W-1:0] TOP_C    = (CMP_W'(1) << (SAMPLE_WIDTH - 1)) - CMP_W'(1);
   localparam logic signed [CMP_W-1:0] BOT_C    = -(CMP_W'(1) << (SAMPLE_WIDTH - 1));

   // cos(i/(E-1)) by a Q30 series up to the x^10 term, rounded to Q1.22
   function automatic logic [COS_W-1:0] cos_entry(input int unsigned i);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] rnd;
      x    = ((64'(i) << 30) + 64'(COS_DEN / 2)) / 64'(COS_DEN);
      x2   = (x * x) >> 30;
      term = 64'd1 << 30;
      sum  = term;
      term = ((term * x2) >> 30) / 64'd2;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd12;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd30;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd56;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd90;
      sum  = sum - term;
      rnd  = (sum + 64'd128) >> 8;
      return rnd[COS_W-1:0];
   endfunction

   logic [COS_W-1:0] cos_rom [COS_TABLE_ENTRIES];

   for (genvar g = 0; g < COS_TABLE_ENTRIES; g++) begin : g_rom
      assign cos_rom[g] = cos_entry(g);
   end

   logic signed [SAMPLE_WIDTH-1:0] x_ff, x_in;
   logic signed [SAMPLE_WIDTH-1:0] last_ff, last_in;
   logic [SQ_W-1:0]                sq_ff, sq_in;
   logic [IDX_W-1:0]               idx_ff, idx_in;
   logic [COS_W-1:0]               cos_ff, cos_in;
   logic [SAMPLE_WIDTH-1:0]        step_ff, step_in;

   logic [SAMPLE_WIDTH-1:0] last_abs;
   logic [MAG_W-1:0]        mag;
   logic [2*MAG_W-1:0]      sq_full;
   logic [IPROD_W-1:0]      idx_prod;
   logic [SPROD_W-1:0]      step_prod;
   logic signed [CMP_W-1:0] xe, pe, se, d, y, keep, ysat_w;

   // the step's table index depends only on the stored value, so square it at load
   assign last_abs = last_ff[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-last_ff) : last_ff;
   assign mag      = last_abs[MAG_W-1:0];
   assign sq_full  = mag * mag;
   assign sq_in    = sq_full[SQ_SHIFT +: SQ_W];

   assign idx_prod = IPROD_W'(sq_ff) * IPROD_W'(COS_DEN) + IDX_HALF;
   assign idx_in   = idx_prod[SQ_FRAC +: IDX_W];

   assign cos_in    = cos_rom[idx_ff];
   assign step_prod = SPROD_W'(thresh) * SPROD_W'(cos_ff) + STEP_HALF;
   assign step_in   = step_prod[STEP_SHIFT +: SAMPLE_WIDTH];

   assign xe = CMP_W'(x_ff);
   assign pe = CMP_W'(last_ff);
   assign se = CMP_W'(step_ff);
   assign d  = xe - pe;

   always_comb begin
      priority if (d > se) begin
         y = pe + se;
      end else if (-d > se) begin
         y = pe - se;
      end else begin
         y = xe;
      end
   end

   always_comb begin
      priority if (y > UNITY_C) begin
         keep = UNITY_C;
      end else if (y < NUNITY_C) begin
         keep = NUNITY_C;
      end else begin
         keep = y;
      end
   end

   always_comb begin
      priority if (y > TOP_C) begin
         ysat_w = TOP_C;
      end else if (y < BOT_C) begin
         ysat_w = BOT_C;
      end else begin
         ysat_w = y;
      end
   end

   assign y_sat   = ysat_w[SAMPLE_WIDTH-1:0];
   assign x_in    = ctrl.load ? sample : x_ff;
   assign last_in = ctrl.commit ? keep[SAMPLE_WIDTH-1:0] : last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
      end else begin
         last_ff <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      if (ctrl.load) begin
         sq_ff <= sq_in;
      end
      if (ctrl.index) begin
         idx_ff <= idx_in;
      end
      if (ctrl.lookup) begin
         cos_ff <= cos_in;
      end
      if (ctrl.scale) begin
         step_ff <= step_in;
      end
   end

   `SLDSL_ASSERT_NOW(a_last_bounded, 1'b1, (pe <= UNITY_C) && (pe >= NUNITY_C), "stored value beyond unity")
   `SLDSL_ASSERT_NOW(a_index_in_rom, ctrl.lookup, idx_ff <= IDX_W'(COS_DEN), "cosine index beyond table")
   `SLDSL_ASSERT_NEXT(a_last_held, ctrl.load, $stable(last_ff), "stored value moved before commit")

endmodule

>>> sv/sldsl_merge.sv
// Output stage: joins both lane results into one response and holds it.
// Depends on sldsl_rsp_if.
`timescale 1ns / 1ps

module sldsl_merge #(
   parameter int SAMPLE_WIDTH = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           commit,
   input  logic signed [SAMPLE_WIDTH-1:0] left_y,
   input  logic signed [SAMPLE_WIDTH-1:0] right_y,
   output logic                           slot_free,
   sldsl_rsp_if.source                    rsp_chan
);
   logic                           valid_ff, valid_in;
   logic signed [SAMPLE_WIDTH-1:0] left_ff;
   logic signed [SAMPLE_WIDTH-1:0] right_ff;

   assign slot_free = !valid_ff || rsp_chan.ready;

   // a commit only comes when the slot is free, so it always wins
   always_comb begin
      priority if (commit) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         left_ff  <= left_y;
         right_ff <= right_y;
      end
   end

   assign rsp_chan.valid     = valid_ff;
   assign rsp_chan.out_left  = left_ff;
   assign rsp_chan.out_right = right_ff;

endmodule

>>> sv/stereo_level_dependent_slew_limiter.sv
// A request is taken only when idle; its response is registered at commit.
// Each request runs the square, cosine index, table read, step scale and
// limit steps in turn, and the next request needs the value this one stores.
// A held response stalls the limit step, and with it the next request.
// Reset (synchronous): stored values to zero, threshold to 1.0, no response.
`timescale 1ns / 1ps
`include "stereo_level_dependent_slew_limiter_macros.svh"

module stereo_level_dependent_slew_limiter #(
   parameter int COS_TABLE_ENTRIES = 256,
   parameter int SAMPLE_WIDTH      = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [sldsl_pkg::THRESH_W-1:0] csr_wr_data,
   sldsl_req_if.sink                      req_chan,
   sldsl_rsp_if.source                    rsp_chan
);
   import sldsl_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_INDEX  = 5'b00010,
      ST_LOOKUP = 5'b00100,
      ST_SCALE  = 5'b01000,
      ST_LIMIT  = 5'b10000
   } state_type;

   state_type               state_ff, state_in;
   logic [THRESH_W-1:0]     thresh_ff, thresh_in;
   sldsl_ctrl_type          ctrl;
   logic                    accept;
   logic                    slot_free;
   logic signed [SAMPLE_WIDTH-1:0] left_y;
   logic signed [SAMPLE_WIDTH-1:0] right_y;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_INDEX;
            end
         end
         ST_INDEX:  state_in = ST_LOOKUP;
         ST_LOOKUP: state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_LIMIT;
         ST_LIMIT: begin
            // hold until the output slot can take the response
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   assign ctrl.load   = accept;
   assign ctrl.index  = (state_ff == ST_INDEX);
   assign ctrl.lookup = (state_ff == ST_LOOKUP);
   assign ctrl.scale  = (state_ff == ST_SCALE);
   assign ctrl.commit = (state_ff == ST_LIMIT) && slot_free;

   assign thresh_in = csr_wr_en ? csr_wr_data : thresh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         thresh_ff <= THRESH_RESET;
      end else begin
         state_ff  <= state_in;
         thresh_ff <= thresh_in;
      end
   end

   sldsl_lane #(
      .COS_TABLE_ENTRIES (COS_TABLE_ENTRIES),
      .SAMPLE_WIDTH      (SAMPLE_WIDTH)
   ) u_lane_left (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .thresh (thresh_ff),
      .sample (req_chan.sample_left),
      .y_sat  (left_y)
   );

   sldsl_lane #(
      .COS_TABLE_ENTRIES (COS_TABLE_ENTRIES),
      .SAMPLE_WIDTH      (SAMPLE_WIDTH)
   ) u_lane_right (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .thresh (thresh_ff),
      .sample (req_chan.sample_right),
      .y_sat  (right_y)
   );

   sldsl_merge #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .commit    (ctrl.commit),
      .left_y    (left_y),
      .right_y   (right_y),
      .slot_free (slot_free),
      .rsp_chan  (rsp_chan)
   );

   `SLDSL_ASSERT_NEXT(a_accept_starts, accept, state_ff == ST_INDEX, "accepted request did not start")
   `SLDSL_ASSERT_NEXT(a_commit_shows, ctrl.commit, rsp_chan.valid, "committed response not shown")
   `SLDSL_ASSERT_NEXT(a_limit_holds, (state_ff == ST_LIMIT) && !slot_free, state_ff == ST_LIMIT, "limit step left while output full")

endmodule

>>> dv/stereo_level_dependent_slew_limiter_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the stereo level-dependent slew limiter.
// Needs sldsl_pkg, the channel interfaces of sldsl_if.sv and the block itself.

module stereo_level_dependent_slew_limiter_test;
   import sldsl_pkg::*;

   localparam int SAMPLE_W        = 24;
   localparam int FRAC            = SAMPLE_W - 2;
   localparam int COS_ENTRIES     = 256;
   localparam int QUIET_LIMIT     = 2000;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 190;
   localparam longint UNITY  = longint'(1) << FRAC;
   localparam longint TOP    = (longint'(1) << (SAMPLE_W - 1)) - 1;
   localparam longint BOTTOM = -TOP - 1;
   localparam logic [THRESH_W-1:0] THRESH_MAX = {THRESH_W{1'b1}};

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef struct {
      sample_type left;
      sample_type right;
   } stereo_pair_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_wr_en;
   logic [THRESH_W-1:0] csr_wr_data;

   sldsl_req_if #(.SAMPLE_WIDTH(SAMPLE_W)) req_chan ();
   sldsl_rsp_if #(.SAMPLE_WIDTH(SAMPLE_W)) rsp_chan ();

   stereo_level_dependent_slew_limiter #(
      .COS_TABLE_ENTRIES(COS_ENTRIES),
      .SAMPLE_WIDTH     (SAMPLE_W)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan)
   );

   always #5 clock = ~clock;

   // predictor state: cosine table, step threshold and held level per lane
   longint unsigned     cos_q22 [COS_ENTRIES];
   logic [THRESH_W-1:0] step_base;
   longint              held_left;
   longint              held_right;

   stereo_pair_type pending_requests [$];
   stereo_pair_type expected_outputs [$];
   stereo_pair_type next_pair;
   stereo_pair_type want_pair;
   stereo_pair_type taken_pair;

   int req_gap;
   int rsp_gap;
   int req_idle_pct;
   int rsp_idle_pct;
   int mismatches;
   int quiet_cycles;

   function automatic void fill_cosine_table();
      longint unsigned den, x, x2, term, sum;
      den = 64'(COS_ENTRIES - 1);
      for (int i = 0; i < COS_ENTRIES; i++) begin
         x    = ((64'(i) << 30) + den / 2) / den;
         x2   = (x * x) >> 30;
         term = 64'd1 << 30;
         sum  = term;
         // Taylor series of the cosine up to the tenth power
         for (int k = 1; k <= 5; k++) begin
            term = ((term * x2) >> 30) / (64'(2 * k - 1) * 64'(2 * k));
            if (k % 2 == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         cos_q22[i] = (sum + 64'd128) >> 8;
      end
   endfunction

   function automatic sample_type limit_lane(input sample_type x, inout longint held);
      longint unsigned mag, sq28, idx, prod;
      longint          step, diff, y;
      mag  = (held < 0) ? -held : held;
      sq28 = (mag * mag) >> (2 * FRAC - 28);
      idx  = (sq28 * 64'(COS_ENTRIES - 1) + (64'd1 << 27)) >> 28;
      if (idx > 64'(COS_ENTRIES - 1)) begin
         idx = 64'(COS_ENTRIES - 1);
      end
      prod = 64'(step_base) * cos_q22[idx];
      step = signed'((prod + (64'd1 << (43 - FRAC))) >> (44 - FRAC));
      diff = longint'(x) - held;
      y    = x;
      if (diff > step) begin
         y = held + step;
      end
      if (-diff > step) begin
         y = held - step;
      end
      // hold the unsaturated level, clamped to plus or minus one
      held = (y > UNITY) ? UNITY : ((y < -UNITY) ? -UNITY : y);
      if (y > TOP) begin
         y = TOP;
      end
      if (y < BOTTOM) begin
         y = BOTTOM;
      end
      return sample_type'(y);
   endfunction

   function automatic stereo_pair_type predict_limited_pair(input stereo_pair_type in_pair);
      stereo_pair_type out_pair;
      out_pair.left  = limit_lane(in_pair.left, held_left);
      out_pair.right = limit_lane(in_pair.right, held_right);
      return out_pair;
   endfunction

   // random walk of one lane: mostly small and medium moves, some jumps and extremes
   function automatic longint next_level(inout longint g);
      int unsigned pick;
      longint      delta;
      pick = $urandom_range(99);
      if (pick < 45) begin
         delta = longint'($urandom_range(0, 1 << $urandom_range(16)));
         g = $urandom_range(1) ? g + delta : g - delta;
      end else if (pick < 70) begin
         delta = longint'($urandom_range(0, 1 << $urandom_range(17, 22)));
         g = $urandom_range(1) ? g + delta : g - delta;
      end else if (pick < 85) begin
         g = longint'(sample_type'($urandom));
      end else if (pick < 93) begin
         case ($urandom_range(4))
            0: g = TOP;
            1: g = BOTTOM;
            2: g = UNITY;
            3: g = -UNITY;
            default: g = 0;
         endcase
      end
      if (g > TOP) begin
         g = TOP;
      end
      if (g < BOTTOM) begin
         g = BOTTOM;
      end
      return g;
   endfunction

   task automatic queue_pair(input longint l, input longint r);
      pending_requests.push_back('{left: sample_type'(l), right: sample_type'(r)});
   endtask

   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (pending_requests.size() != 0 || req_chan.valid
                 || expected_outputs.size() != 0);
   endtask

   task automatic write_threshold(input logic [THRESH_W-1:0] level);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= level;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      step_base = level;
      @(negedge clock);
   endtask

   // request driver: predict on acceptance, then present the next pending request
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            taken_pair.left  = req_chan.sample_left;
            taken_pair.right = req_chan.sample_right;
            expected_outputs.push_back(predict_limited_pair(taken_pair));
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (req_gap > 0) begin
               req_gap = req_gap - 1;
               req_chan.valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
               next_pair = pending_requests.pop_front();
               req_chan.valid        <= 1'b1;
               req_chan.sample_left  <= next_pair.left;
               req_chan.sample_right <= next_pair.right;
               if ($urandom_range(99) < req_idle_pct) begin
                  req_gap = $urandom_range(1, 12);
               end
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor with random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_gap = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_outputs.size() == 0) begin
               $error("response with no request outstanding: out_left %0d, out_right %0d",
                      rsp_chan.out_left, rsp_chan.out_right);
               mismatches++;
            end else begin
               want_pair = expected_outputs.pop_front();
               if (rsp_chan.out_left !== want_pair.left) begin
                  $error("out_left mismatch: expected %0d, actual %0d",
                         want_pair.left, rsp_chan.out_left);
                  mismatches++;
               end
               if (rsp_chan.out_right !== want_pair.right) begin
                  $error("out_right mismatch: expected %0d, actual %0d",
                         want_pair.right, rsp_chan.out_right);
                  mismatches++;
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap = rsp_gap - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            if ($urandom_range(99) < rsp_idle_pct) begin
               rsp_gap = $urandom_range(1, 12);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready)
          || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      longint              walk_left;
      longint              walk_right;
      logic [THRESH_W-1:0] level;

      reset                 = 1'b1;
      csr_wr_en             = 1'b0;
      csr_wr_data           = '0;
      req_chan.valid        = 1'b0;
      req_chan.sample_left  = '0;
      req_chan.sample_right = '0;
      rsp_chan.ready        = 1'b0;
      mismatches            = 0;
      quiet_cycles          = 0;
      req_idle_pct          = 30;
      rsp_idle_pct          = 30;
      fill_cosine_table();
      step_base  = THRESH_RESET;
      held_left  = 0;
      held_right = 0;
      walk_left  = 0;
      walk_right = 0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // threshold left at its reset value of one
      queue_pair(0, 0);
      queue_pair(TOP, BOTTOM);
      queue_pair(TOP, BOTTOM);
      queue_pair(UNITY, -UNITY);
      queue_pair(UNITY + 1, -UNITY - 1);
      queue_pair(BOTTOM, TOP);
      queue_pair(1, -1);
      queue_pair(0, 0);
      queue_pair(UNITY / 2, -UNITY / 2);
      queue_pair(UNITY / 2, -UNITY / 2);
      queue_pair(TOP, TOP);
      queue_pair(-1, TOP);
      wait_drained();

      // zero step: only an input equal to the held level passes
      write_threshold('0);
      queue_pair(held_left, held_right);
      queue_pair(held_left + 1, held_right - 1);
      queue_pair(TOP, BOTTOM);
      queue_pair(held_left, held_right);
      wait_drained();

      // largest step: stored level clamps at plus or minus one
      write_threshold(THRESH_MAX);
      queue_pair(TOP, BOTTOM);
      queue_pair(TOP, BOTTOM);
      queue_pair(BOTTOM, TOP);
      queue_pair(BOTTOM, TOP);
      queue_pair(TOP, BOTTOM);
      queue_pair(0, 0);
      wait_drained();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin
               level = THRESH_W'($urandom_range(0, THRESH_MAX));
               req_idle_pct = 30;
               rsp_idle_pct = 30;
            end
            1: begin
               level = THRESH_W'($urandom_range(1, 4096));
               req_idle_pct = 50;
               rsp_idle_pct = 10;
            end
            2: begin
               level = THRESH_MAX;
               req_idle_pct = 20;
               rsp_idle_pct = 40;
            end
            3: begin
               level = THRESH_W'($urandom_range(65536, 1048576));
               req_idle_pct = 0;
               rsp_idle_pct = 40;
            end
            4: begin
               level = THRESH_W'(1);
               req_idle_pct = 40;
               rsp_idle_pct = 0;
            end
            5: begin
               level = THRESH_W'($urandom_range(0, THRESH_MAX));
               req_idle_pct = 25;
               rsp_idle_pct = 25;
            end
            6: begin
               level = THRESH_W'($urandom_range(0, 15));
               req_idle_pct = 15;
               rsp_idle_pct = 15;
            end
            default: begin
               // final stretch runs without idling
               level = THRESH_RESET;
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         write_threshold(level);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            queue_pair(next_level(walk_left), next_level(walk_right));
         end
         wait_drained();
      end

      repeat (8) @(negedge clock);
      if (mismatches == 0 && expected_outputs.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
